// ----- sv/polyline_arc_length_interpolator_defines.svh -----
// Assertion macros shared by the polyline interpolator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef POLYLINE_ARC_LENGTH_INTERPOLATOR_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_INTERPOLATOR_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define PALI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PALI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/pali_pkg.sv -----
// Types and constants of the polyline arc-length interpolator.
// No dependencies; used by pali_ctrl, pali_dp and the top level.
package pali_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] ST_POS_OK = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_ADDED  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam int IterW     = 6;
  localparam int SqrtSteps = 17;
  localparam int DivSteps  = 35;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQX, S_SQY, S_SQRT, S_APPWR, S_QCHK, S_WALK,
    S_RDV0, S_RDV1, S_MULX, S_DIVX, S_MULY, S_DIVY, S_POS, S_EMIT
  } state_e;

  typedef enum logic [4:0] {
    C_NOP, C_LOAD, C_RD_PREV, C_SQ_X, C_SQ_Y, C_SQRT_STEP, C_APP_WR, C_FULL,
    C_DIST, C_BEYOND, C_WALK_RD, C_WALK_CHK, C_RD_V0, C_RD_V1, C_MUL_X,
    C_DIV_STEP, C_MUL_Y, C_POS, C_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic first;
    logic beyond;
    logic found;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

// ----- sv/polyline_arc_length_interpolator.sv -----
// Polyline arc-length interpolator: an append/query stream in, one result out.
// Input channel s_axis: tuser = operation (0 append, 1 query); tdata holds the
// vertex x, y (Q12.4) and the query speed and time. Output channel m_axis:
// tuser = status, tdata = interpolated x, y.
// Each transaction in gives exactly one transaction out, in order.
// Steps from acceptance to result valid: an append runs decode, the squares of
// x and y, the 17-step square root and the store write; a query runs the
// distance product, the walk over the segment memory (one read a cycle) to the
// segment found, two vertex reads and two 35-step restoring divisions. Beyond-path
// queries, the first append and store-full appends skip the arithmetic. One item is worked
// on at a time; s_axis_tready is high while the block waits for the next item,
// which it does from the cycle after the previous result has been issued.
// The result register decouples the sides: a new item is accepted while the
// previous result still waits; when the receiver stalls, the finished result
// of the next item is held until the register is free.
// Reset (rst_ni low, asynchronous) empties the path: vertex count and total
// length go to zero and no result is pending. Stores need no clearing.
// Depends on pali_pkg, pali_ctrl and pali_dp.
module polyline_arc_length_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x[15:0], point_y[31:16], speed[47:32], time_req[63:48]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pos_x[15:0], pos_y[31:16]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  pali_pkg::cmd_t cmd;
  pali_pkg::sts_t sts;

  pali_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pali_dp #(
    .MaxPoints (MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tuser[0]),
    .point_x_i  (s_axis_tdata[15:0]),
    .point_y_i  (s_axis_tdata[31:16]),
    .speed_i    (s_axis_tdata[47:32]),
    .time_req_i (s_axis_tdata[63:48]),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .status_o   (m_axis_tuser),
    .pos_x_o    (m_axis_tdata[15:0]),
    .pos_y_o    (m_axis_tdata[31:16])
  );

endmodule

// ----- sv/pali_ctrl.sv -----
// Controller state machine of the polyline interpolator.
// Depends on pali_pkg; drives pali_dp through command and status structs.
module pali_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  pali_pkg::sts_t  sts_i,
  output pali_pkg::cmd_t  cmd_o
);

  pali_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pali_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pali_pkg::S_IDLE:   if (s_valid_i) state_d = pali_pkg::S_DECODE;
      pali_pkg::S_DECODE: begin
        if (sts_i.is_query) state_d = pali_pkg::S_QCHK;
        else if (sts_i.full || sts_i.first) state_d = (sts_i.full) ? pali_pkg::S_EMIT
                                                                   : pali_pkg::S_APPWR;
        else state_d = pali_pkg::S_SQX;
      end
      pali_pkg::S_SQX:    state_d = pali_pkg::S_SQY;
      pali_pkg::S_SQY:    state_d = pali_pkg::S_SQRT;
      pali_pkg::S_SQRT:   if (sts_i.last) state_d = pali_pkg::S_APPWR;
      pali_pkg::S_APPWR:  state_d = pali_pkg::S_EMIT;
      pali_pkg::S_QCHK:   state_d = (sts_i.beyond) ? pali_pkg::S_EMIT : pali_pkg::S_WALK;
      pali_pkg::S_WALK:   if (sts_i.found) state_d = pali_pkg::S_RDV0;
      pali_pkg::S_RDV0:   state_d = pali_pkg::S_RDV1;
      pali_pkg::S_RDV1:   state_d = pali_pkg::S_MULX;
      pali_pkg::S_MULX:   state_d = pali_pkg::S_DIVX;
      pali_pkg::S_DIVX:   if (sts_i.last) state_d = pali_pkg::S_MULY;
      pali_pkg::S_MULY:   state_d = pali_pkg::S_DIVY;
      pali_pkg::S_DIVY:   if (sts_i.last) state_d = pali_pkg::S_POS;
      pali_pkg::S_POS:    state_d = pali_pkg::S_EMIT;
      pali_pkg::S_EMIT:   if (!sts_i.out_busy) state_d = pali_pkg::S_IDLE;
      default:            state_d = pali_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    cmd_o.cmd = pali_pkg::C_NOP;
    case (state_q)
      pali_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o.cmd = pali_pkg::C_LOAD;
      end
      pali_pkg::S_DECODE: begin
        if (sts_i.is_query) cmd_o.cmd = pali_pkg::C_DIST;
        else if (sts_i.full) cmd_o.cmd = pali_pkg::C_FULL;
        else if (!sts_i.first) cmd_o.cmd = pali_pkg::C_RD_PREV;
      end
      pali_pkg::S_SQX:   cmd_o.cmd = pali_pkg::C_SQ_X;
      pali_pkg::S_SQY:   cmd_o.cmd = pali_pkg::C_SQ_Y;
      pali_pkg::S_SQRT:  cmd_o.cmd = pali_pkg::C_SQRT_STEP;
      pali_pkg::S_APPWR: cmd_o.cmd = pali_pkg::C_APP_WR;
      pali_pkg::S_QCHK:  cmd_o.cmd = (sts_i.beyond) ? pali_pkg::C_BEYOND : pali_pkg::C_WALK_RD;
      pali_pkg::S_WALK:  cmd_o.cmd = pali_pkg::C_WALK_CHK;
      pali_pkg::S_RDV0:  cmd_o.cmd = pali_pkg::C_RD_V0;
      pali_pkg::S_RDV1:  cmd_o.cmd = pali_pkg::C_RD_V1;
      pali_pkg::S_MULX:  cmd_o.cmd = pali_pkg::C_MUL_X;
      pali_pkg::S_DIVX:  cmd_o.cmd = pali_pkg::C_DIV_STEP;
      pali_pkg::S_MULY:  cmd_o.cmd = pali_pkg::C_MUL_Y;
      pali_pkg::S_DIVY:  cmd_o.cmd = pali_pkg::C_DIV_STEP;
      pali_pkg::S_POS:   cmd_o.cmd = pali_pkg::C_POS;
      pali_pkg::S_EMIT:  if (!sts_i.out_busy) cmd_o.cmd = pali_pkg::C_EMIT;
      default:           cmd_o.cmd = pali_pkg::C_NOP;
    endcase
  end

endmodule

// ----- sv/pali_dp.sv -----
// Datapath of the polyline interpolator: vertex and segment memories,
// shared multiplier, square-root and divider iterations, output register.
// Depends on pali_pkg and the assertion macro header.
`include "polyline_arc_length_interpolator_defines.svh"

module pali_dp #(
  parameter int MaxPoints = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pali_pkg::cmd_t  cmd_i,
  output pali_pkg::sts_t  sts_o,
  input  logic            op_i,
  input  logic [15:0]     point_x_i,
  input  logic [15:0]     point_y_i,
  input  logic [15:0]     speed_i,
  input  logic [15:0]     time_req_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [1:0]      status_o,
  output logic [15:0]     pos_x_o,
  output logic [15:0]     pos_y_o
);

  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxPoints + 1);

  logic [31:0] mem_v [MaxPoints];
  logic [17:0] mem_s [MaxPoints];

  logic        op_q;
  logic [15:0] px_q, py_q, spd_q, tim_q;
  logic [CW-1:0] cnt_q;
  logic [23:0] total_q;
  logic [31:0] vrd_q, v0_q;
  logic [17:0] srd_q;
  logic [31:0] a_q;
  logic [33:0] sv_q;
  logic [17:0] srem_q;
  logic [16:0] root_q;
  logic [pali_pkg::IterW-1:0] iter_q;
  logic [31:0] dist_q, sum_q;
  logic [AW-1:0] idx_q;
  logic [17:0] off_q, len_q;
  logic [34:0] dvd_q;
  logic [17:0] drem_q;
  logic        neg_q;
  logic [1:0]  res_st_q;
  logic [15:0] res_x_q, res_y_q;
  logic        m_valid_q;
  logic [1:0]  out_st_q;
  logic [15:0] out_x_q, out_y_q;

  pali_pkg::cmd_e cmd;
  assign cmd = cmd_i.cmd;

  // memory ports
  logic          v_we, v_re, s_we, s_re;
  logic [AW-1:0] v_wa, v_ra, s_wa, s_ra;

  always_ff @(posedge clk_i) begin
    if (v_we) mem_v[v_wa] <= {py_q, px_q};
    if (v_re) vrd_q <= mem_v[v_ra];
    if (s_we) mem_s[s_wa] <= {1'b0, root_q};
    if (s_re) srd_q <= mem_s[s_ra];
  end

  // differences and their magnitudes
  logic [16:0] dx, dy, dvx, dvy, dsel, dmag, dxm, dym;
  assign dx  = {px_q[15], px_q} - {vrd_q[15], vrd_q[15:0]};
  assign dy  = {py_q[15], py_q} - {vrd_q[31], vrd_q[31:16]};
  assign dvx = {vrd_q[15], vrd_q[15:0]} - {v0_q[15], v0_q[15:0]};
  assign dvy = {vrd_q[31], vrd_q[31:16]} - {v0_q[31], v0_q[31:16]};
  assign dxm = dx[16] ? 17'(17'd0 - dx) : dx;
  assign dym = dy[16] ? 17'(17'd0 - dy) : dy;
  assign dsel = (cmd == pali_pkg::C_MUL_Y) ? dvy : dvx;
  assign dmag = dsel[16] ? 17'(17'd0 - dsel) : dsel;

  // shared multiplier
  logic [17:0] mul_a, mul_b;
  logic [35:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      pali_pkg::C_SQ_X: begin
        mul_a = {1'b0, dxm};
        mul_b = {1'b0, dxm};
      end
      pali_pkg::C_SQ_Y: begin
        mul_a = {1'b0, dym};
        mul_b = {1'b0, dym};
      end
      pali_pkg::C_DIST: begin
        mul_a = {2'b0, spd_q};
        mul_b = {2'b0, tim_q};
      end
      pali_pkg::C_MUL_X, pali_pkg::C_MUL_Y: begin
        mul_a = {1'b0, dmag};
        mul_b = off_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // square-root step: two radicand bits per cycle
  logic [19:0] sq_rem, sq_trial;
  logic        sq_ge;
  assign sq_rem   = {srem_q, sv_q[33:32]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  // restoring divider step: one quotient bit per cycle
  logic [18:0] dv_rem;
  logic        dv_ge;
  assign dv_rem = {drem_q, dvd_q[34]};
  assign dv_ge  = dv_rem >= {1'b0, len_q};

  // signed quotient added to the start vertex
  logic [16:0] q_s, base;
  logic [16:0] pos_sum;
  assign q_s     = neg_q ? 17'(17'd0 - dvd_q[16:0]) : dvd_q[16:0];
  assign base    = (cmd == pali_pkg::C_POS) ? {v0_q[31], v0_q[31:16]}
                                            : {v0_q[15], v0_q[15:0]};
  assign pos_sum = base + q_s;

  logic [31:0] sum_n;
  logic [24:0] tot_n;
  assign sum_n = sum_q + {14'd0, srd_q};
  assign tot_n = {1'b0, total_q} + {8'd0, root_q};

  always_comb begin
    v_we = (cmd == pali_pkg::C_APP_WR);
    v_wa = AW'(cnt_q);
    s_we = (cmd == pali_pkg::C_APP_WR) && (cnt_q != '0);
    s_wa = AW'(cnt_q - CW'(1));
    v_re = 1'b0;
    v_ra = AW'(cnt_q - CW'(1));
    s_re = 1'b0;
    s_ra = '0;
    case (cmd)
      pali_pkg::C_RD_PREV: v_re = 1'b1;
      pali_pkg::C_RD_V0: begin
        v_re = 1'b1;
        v_ra = idx_q;
      end
      pali_pkg::C_RD_V1: begin
        v_re = 1'b1;
        v_ra = AW'(idx_q + AW'(1));
      end
      pali_pkg::C_WALK_RD: s_re = 1'b1;
      pali_pkg::C_WALK_CHK: begin
        s_re = 1'b1;
        s_ra = AW'(idx_q + AW'(1));
      end
      default: begin
        v_re = 1'b0;
        s_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd)
      pali_pkg::C_LOAD: begin
        op_q  <= op_i;
        px_q  <= point_x_i;
        py_q  <= point_y_i;
        spd_q <= speed_i;
        tim_q <= time_req_i;
      end
      pali_pkg::C_SQ_X: a_q <= prod[31:0];
      pali_pkg::C_SQ_Y: begin
        sv_q   <= {2'b0, a_q} + {2'b0, prod[31:0]};
        srem_q <= '0;
        root_q <= '0;
        iter_q <= '0;
      end
      pali_pkg::C_SQRT_STEP: begin
        srem_q <= sq_ge ? 18'(sq_rem - sq_trial) : sq_rem[17:0];
        root_q <= {root_q[15:0], sq_ge};
        sv_q   <= {sv_q[31:0], 2'b00};
        iter_q <= iter_q + pali_pkg::IterW'(1);
      end
      pali_pkg::C_APP_WR: begin
        res_st_q <= pali_pkg::ST_ADDED;
        res_x_q  <= '0;
        res_y_q  <= '0;
      end
      pali_pkg::C_FULL: begin
        res_st_q <= pali_pkg::ST_FULL;
        res_x_q  <= '0;
        res_y_q  <= '0;
      end
      pali_pkg::C_DIST: dist_q <= prod[31:0];
      pali_pkg::C_BEYOND: begin
        res_st_q <= pali_pkg::ST_BEYOND;
        res_x_q  <= 16'hFFF0;
        res_y_q  <= 16'hFFF0;
      end
      pali_pkg::C_WALK_RD: begin
        idx_q <= '0;
        sum_q <= '0;
      end
      pali_pkg::C_WALK_CHK: begin
        if (sum_n > dist_q) begin
          off_q <= 18'(dist_q - sum_q);
          len_q <= srd_q;
        end else begin
          sum_q <= sum_n;
          idx_q <= AW'(idx_q + AW'(1));
        end
      end
      pali_pkg::C_RD_V1: v0_q <= vrd_q;
      pali_pkg::C_MUL_X: begin
        dvd_q  <= prod[34:0];
        neg_q  <= dvx[16];
        drem_q <= '0;
        iter_q <= '0;
      end
      pali_pkg::C_DIV_STEP: begin
        drem_q <= dv_ge ? 18'(dv_rem - {1'b0, len_q}) : dv_rem[17:0];
        dvd_q  <= {dvd_q[33:0], dv_ge};
        iter_q <= iter_q + pali_pkg::IterW'(1);
      end
      pali_pkg::C_MUL_Y: begin
        res_x_q <= pos_sum[15:0];
        dvd_q   <= prod[34:0];
        neg_q   <= dvy[16];
        drem_q  <= '0;
        iter_q  <= '0;
      end
      pali_pkg::C_POS: begin
        res_y_q  <= pos_sum[15:0];
        res_st_q <= pali_pkg::ST_POS_OK;
      end
      pali_pkg::C_EMIT: begin
        out_st_q <= res_st_q;
        out_x_q  <= res_x_q;
        out_y_q  <= res_y_q;
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

  // control state: vertex count, total length, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd == pali_pkg::C_APP_WR) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q != '0) total_q <= tot_n[24] ? 24'hFFFFFF : tot_n[23:0];
      end
      if (cmd == pali_pkg::C_EMIT) m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_query = (op_q == pali_pkg::OP_QUERY);
  assign sts_o.full     = cnt_q >= CW'(MaxPoints);
  assign sts_o.first    = (cnt_q == '0);
  assign sts_o.beyond   = (cnt_q < CW'(2)) || (dist_q >= {8'd0, total_q});
  assign sts_o.found    = sum_n > dist_q;
  assign sts_o.last     = ((cmd == pali_pkg::C_SQRT_STEP) &&
                           (iter_q == pali_pkg::IterW'(pali_pkg::SqrtSteps - 1))) ||
                          ((cmd == pali_pkg::C_DIV_STEP) &&
                           (iter_q == pali_pkg::IterW'(pali_pkg::DivSteps - 1)));
  assign sts_o.out_busy = m_valid_q && !m_ready_i;

  assign m_valid_o = m_valid_q;
  assign status_o  = out_st_q;
  assign pos_x_o   = out_x_q;
  assign pos_y_o   = out_y_q;

  `PALI_ASSERT(a_cnt_bound, cnt_q <= CW'(MaxPoints), "vertex count beyond store depth")
  `PALI_ASSERT(a_total_hold, (cmd != pali_pkg::C_APP_WR) |=> $stable(total_q), "total moved without an append")
  `PALI_ASSERT(a_emit_no_overwrite, (cmd == pali_pkg::C_EMIT) |-> !(m_valid_q && !m_ready_i), "result register overwritten while stalled")
  `PALI_ASSERT_ALWAYS(a_valid_rise, $rose(m_valid_q) |-> $past(cmd == pali_pkg::C_EMIT), "result valid without emit")

endmodule

// ----- tb/sv/tb_polyline_arc_length_interpolator.sv -----
// Testbench for polyline_arc_length_interpolator: appends and queries on s_axis,
// results on m_axis checked against an in-bench path predictor.
// Depends on pali_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_polyline_arc_length_interpolator;

  localparam int MaxPts = 64;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } position_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // point_x[15:0], point_y[31:16], speed[47:32], time_req[63:48]
  logic [0:0]  s_axis_tuser = '0;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // pos_x[15:0], pos_y[31:16]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  polyline_arc_length_interpolator #(.MAX_POINTS(MaxPts)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #1 clk_i = ~clk_i;

  // predictor copy of the path
  logic signed [15:0] path_x[MaxPts];
  logic signed [15:0] path_y[MaxPts];
  logic [17:0]        seg_len[MaxPts];
  logic [23:0]        total_len;
  int                 n_vertices;

  position_t expected_positions[$];
  int  mismatches = 0;
  bit  timed_out = 1'b0;
  int  send_idle_pct, recv_idle_pct;
  int  idle_cycles = 0;

  function automatic logic [31:0] isqrt(logic [33:0] v);
    logic [33:0] res, bitv;
    res = '0;
    bitv = 34'd1 << 32;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b,
                                       longint off, longint len);
    longint d;
    d = longint'(b) - longint'(a);
    return 16'(longint'(a) + (d * off) / len);
  endfunction

  function automatic position_t predict_position(logic op, logic signed [15:0] px,
                                                 logic signed [15:0] py,
                                                 logic [15:0] spd, logic [15:0] tq);
    position_t r;
    longint dx, dy, distance, sum;
    logic [31:0] len;
    logic [24:0] t;
    r = '{status: pali_pkg::ST_BEYOND, pos_x: 16'hFFF0, pos_y: 16'hFFF0};
    if (op == pali_pkg::OP_APPEND) begin
      r.pos_x = '0;
      r.pos_y = '0;
      if (n_vertices >= MaxPts) begin
        r.status = pali_pkg::ST_FULL;
      end else begin
        if (n_vertices > 0) begin
          dx = longint'(px) - longint'(path_x[n_vertices-1]);
          dy = longint'(py) - longint'(path_y[n_vertices-1]);
          len = isqrt(34'(dx * dx + dy * dy));
          seg_len[n_vertices-1] = len[17:0];
          t = {1'b0, total_len} + 25'(len[17:0]);
          total_len = t[24] ? 24'hFFFFFF : t[23:0];
        end
        path_x[n_vertices] = px;
        path_y[n_vertices] = py;
        n_vertices++;
        r.status = pali_pkg::ST_ADDED;
      end
    end else begin
      distance = longint'(spd) * longint'(tq);
      if (n_vertices >= 2 && distance < longint'(total_len)) begin
        sum = 0;
        for (int i = 1; i < n_vertices; i++) begin
          sum += seg_len[i-1];
          if (sum > distance) begin
            r.status = pali_pkg::ST_POS_OK;
            r.pos_x = lerp(path_x[i-1], path_x[i], distance - (sum - seg_len[i-1]),
                           seg_len[i-1]);
            r.pos_y = lerp(path_y[i-1], path_y[i], distance - (sum - seg_len[i-1]),
                           seg_len[i-1]);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  // called at a falling edge; valid stays high between back-to-back items
  task automatic send_item(logic op, logic [15:0] px, logic [15:0] py,
                           logic [15:0] spd, logic [15:0] tq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tq, spd, py, px};
    expected_positions = {expected_positions, predict_position(op, px, py, spd, tq)};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic append_vertex(logic [15:0] px, logic [15:0] py);
    send_item(pali_pkg::OP_APPEND, px, py, 16'($urandom), 16'($urandom));
  endtask

  task automatic query_position(logic [15:0] spd, logic [15:0] tq);
    send_item(pali_pkg::OP_QUERY, 16'($urandom), 16'($urandom), spd, tq);
  endtask

  // query distances mostly inside the path so the walk and interpolation run
  task automatic query_inside();
    int unsigned d;
    logic [15:0] spd;
    if (total_len == 0 || $urandom_range(9) == 0) begin
      query_position(16'($urandom), 16'($urandom));
    end else begin
      d = $urandom_range(total_len + total_len / 8);
      spd = 16'($urandom_range(1, 16));
      query_position(spd, 16'(d / spd));
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_positions.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic test_directed();
    query_position(16'd0, 16'd0);              // no vertices
    append_vertex(16'h8000, 16'h8000);
    query_position(16'd0, 16'd0);              // single vertex
    append_vertex(16'h7FFF, 16'h7FFF);         // longest diagonal
    append_vertex(16'h7FFF, 16'h7FFF);         // zero-length segment
    append_vertex(16'h8000, 16'h7FFF);
    append_vertex(16'h0010, 16'hFFF0);
    query_position(16'd0, 16'd0);
    query_position(16'd1, 16'd1);
    query_position(16'd181, 16'd500);
    query_position(16'd1000, 16'd140);
    query_position(16'hFFFF, 16'hFFFF);        // beyond the end
    query_position(16'd1, 16'(total_len - 1));
    query_position(16'd1, 16'(total_len));
  endtask

  task automatic test_fill_store();
    while (n_vertices < MaxPts + 3) begin
      if (n_vertices >= MaxPts) begin
        append_vertex(16'($urandom), 16'($urandom));     // dropped, store full
        if ($urandom_range(2) == 0) break;
      end else begin
        append_vertex(16'($urandom), 16'($urandom));
      end
      if ($urandom_range(3) == 0) query_inside();
    end
    repeat (4) append_vertex(16'($urandom), 16'($urandom));
    repeat (10) query_inside();
  endtask

  task automatic test_random_paths(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        // small steps keep many segments short and the walk long
        if ($urandom_range(1) == 0 && n_vertices > 0)
          append_vertex(path_x[n_vertices-1] + 16'($urandom_range(0, 64) - 32),
                        path_y[n_vertices-1] + 16'($urandom_range(0, 64) - 32));
        else
          append_vertex(16'($urandom), 16'($urandom));
      end else begin
        query_inside();
      end
      sent++;
    end
  endtask

  task automatic set_idling(int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  // receiver stall and result check
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    position_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h/%h", m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_positions.pop_front();
          if (want.status !== m_axis_tuser || want.pos_x !== m_axis_tdata[15:0] ||
              want.pos_y !== m_axis_tdata[31:16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d x=%h y=%h, got st=%0d x=%h y=%h",
                       want.status, want.pos_x, want.pos_y, m_axis_tuser,
                       m_axis_tdata[15:0], m_axis_tdata[31:16]);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    total_len = '0;
    n_vertices = 0;
    set_idling(16, 64);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_fill_store();
    // the path restarts only through reset, which is not applied again, so later phases query the full path
    test_random_paths(200);
    set_idling(64, 16);
    test_random_paths(200);
    set_idling(0, 0);
    test_random_paths(200);
    wait_drained();
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
